// ===== hdl/nds_pkg.sv =====
// Shared constants and types for the non-dominated sort block.
`default_nettype none
package nds_pkg;
    localparam int MAX_POINTS = 64;
    localparam int MAX_OBJECTIVES = 8;
    localparam int PT_W = $clog2(MAX_POINTS);
    localparam int OBJ_W = $clog2(MAX_OBJECTIVES);
    localparam int CNT_W = PT_W + 1;
    localparam int NOBJ_W = 4;
    localparam int VAL_W = 32;
    localparam int RANK_W = 6;
    localparam int ST_DEPTH = MAX_POINTS * MAX_OBJECTIVES;
    localparam int ST_AW = PT_W + OBJ_W;
    localparam int MX_W = RANK_W + MAX_POINTS;
    localparam logic [NOBJ_W-1:0] NOBJ_RESET = NOBJ_W'(2);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FILL,
        S_CACHE,
        S_CMP,
        S_CMP_DRAIN,
        S_ROW_WR,
        S_PEEL,
        S_PEEL_DRAIN,
        S_PEEL_END,
        S_EMIT,
        S_EMIT_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_CACHE,
        RD_CMP,
        RD_PEEL,
        RD_EMIT
    } t_rd;
endpackage
`default_nettype wire

// ===== hdl/nds_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module nds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/fast_non_dominated_sort.sv =====
// Top level: NSGA-II fast non-dominated sort over a streamed point set.
//
//  channel    | handshake          | payload
//  -----------+--------------------+------------------------------------------
//  request    | start / busy       | i_objective_value, i_last_of_set
//  result     | o_strobe           | o_point_index, o_front_rank,
//             |                    | o_last_result, o_truncated
//  config     | i_cfg_we           | i_cfg_wdata (num_objectives)
//
// Loading accepts one request per cycle while busy is low; a stored point
// that closes before its eighth objective zero-fills each remaining store
// slot through the objective store write port, with busy high meanwhile.
// After the last request the sort builds the dominance matrix, then sweeps
// the rows once for each front plus one more sweep, then emits the results.
// The single read port of each RAM serialises these steps.
// Reset is synchronous and active low; it clears control state only, the
// RAMs need no clearing pass. Results come one per cycle, one cycle each;
// the receiver cannot stall them.
`default_nettype none
module fast_non_dominated_sort (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_cfg_we,
    input  wire logic        [nds_pkg::NOBJ_W-1:0]    i_cfg_wdata,
    input  wire logic signed [nds_pkg::VAL_W-1:0]     i_objective_value,
    input  wire logic                                 i_last_of_set,
    output logic                                      o_strobe,
    output logic             [nds_pkg::PT_W-1:0]      o_point_index,
    output logic             [nds_pkg::RANK_W-1:0]    o_front_rank,
    output logic                                      o_last_result,
    output logic                                      o_truncated
);
    import nds_pkg::*;

    // control
    t_state r_state, n_state;
    t_rd    r_rd_kind, n_rd_kind;
    logic [NOBJ_W-1:0] r_nobj;
    logic [CNT_W-1:0]  r_pc, n_pc;
    logic [OBJ_W-1:0]  r_pos, n_pos;
    logic              r_ovf, n_ovf;
    logic [OBJ_W-1:0]  r_fill_k, n_fill_k;
    logic [PT_W-1:0]   r_fill_pt, n_fill_pt;
    logic              r_last_pend, n_last_pend;
    logic [PT_W-1:0]   r_i, n_i;
    logic [PT_W-1:0]   r_j, n_j;
    logic [OBJ_W-1:0]  r_k, n_k;
    logic [PT_W-1:0]   r_rd_j, n_rd_j;
    logic [OBJ_W-1:0]  r_rd_k, n_rd_k;
    logic              r_rd_last, n_rd_last;

    // datapath
    logic signed [VAL_W-1:0] r_cache [MAX_OBJECTIVES];
    logic              r_le, n_le;
    logic              r_lt, n_lt;
    logic [MAX_POINTS-1:0] r_row, n_row;
    logic [MAX_POINTS-1:0] r_ranked, n_ranked;
    logic [MAX_POINTS-1:0] r_front, n_front;
    logic [MAX_POINTS-1:0] r_blocked, n_blocked;
    logic [RANK_W-1:0] r_fnum, n_fnum;

    // RAM ports
    logic              st_we;
    logic [ST_AW-1:0]  st_waddr, st_raddr;
    logic [VAL_W-1:0]  st_wdata, st_rdata;
    logic              mx_we;
    logic [PT_W-1:0]   mx_waddr, mx_raddr;
    logic [MX_W-1:0]   mx_wdata, mx_rdata;

    // helpers
    logic [OBJ_W-1:0]  mlast;
    logic [PT_W-1:0]   nlast;
    logic              accept, stored, closes;
    logic              k_end, i_end, j_end;
    logic [MAX_POINTS-1:0] valid_mask, ranked_new, next_front;
    logic signed [VAL_W-1:0] cmp_x, cmp_y;
    logic              le_acc, lt_acc;

    // Effective objective count minus one: zero acts as one, large clamps.
    always_comb begin
        if (r_nobj == '0) begin
            mlast = '0;
        end else if (r_nobj > NOBJ_W'(MAX_OBJECTIVES)) begin
            mlast = OBJ_W'(MAX_OBJECTIVES - 1);
        end else begin
            mlast = OBJ_W'(r_nobj - NOBJ_W'(1));
        end
    end

    assign nlast  = PT_W'(r_pc - CNT_W'(1));
    assign busy   = (r_state != S_LOAD);
    assign accept = start && !busy;
    assign stored = (r_pc < CNT_W'(MAX_POINTS));
    assign closes = i_last_of_set || (r_pos >= mlast);
    assign k_end  = (r_k == mlast);
    assign i_end  = (r_i == nlast);
    assign j_end  = (r_j == nlast);

    always_comb begin
        for (int b = 0; b < MAX_POINTS; b++) begin
            valid_mask[b] = (CNT_W'(b) < r_pc);
        end
    end

    assign ranked_new = r_ranked | r_front;
    assign next_front = valid_mask & ~ranked_new & ~r_blocked;

    // Running dominance test of the cached point against the returning one.
    assign cmp_x  = r_cache[r_rd_k];
    assign cmp_y  = $signed(st_rdata);
    assign le_acc = ((r_rd_k == '0) ? 1'b1 : r_le) && (cmp_x <= cmp_y);
    assign lt_acc = ((r_rd_k == '0) ? 1'b0 : r_lt) || (cmp_x < cmp_y);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (accept && closes) begin
                    if (stored && (r_pos != OBJ_W'(MAX_OBJECTIVES - 1))) begin
                        n_state = S_FILL;
                    end else if (i_last_of_set) begin
                        n_state = S_CACHE;
                    end
                end
            end
            S_FILL: begin
                if (r_fill_k == OBJ_W'(MAX_OBJECTIVES - 1)) begin
                    n_state = r_last_pend ? S_CACHE : S_LOAD;
                end
            end
            S_CACHE: begin
                if (k_end) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (k_end && j_end) begin
                    n_state = S_CMP_DRAIN;
                end
            end
            S_CMP_DRAIN:  n_state = S_ROW_WR;
            S_ROW_WR:     n_state = i_end ? S_PEEL : S_CACHE;
            S_PEEL: begin
                if (i_end) begin
                    n_state = S_PEEL_DRAIN;
                end
            end
            S_PEEL_DRAIN: n_state = S_PEEL_END;
            S_PEEL_END:   n_state = (ranked_new == valid_mask) ? S_EMIT : S_PEEL;
            S_EMIT: begin
                if (j_end) begin
                    n_state = S_EMIT_DRAIN;
                end
            end
            S_EMIT_DRAIN: n_state = S_LOAD;
            default:      n_state = S_LOAD;
        endcase
    end

    // Datapath, RAM ports and counters.
    always_comb begin
        n_rd_kind   = RD_NONE;
        n_rd_j      = r_rd_j;
        n_rd_k      = r_rd_k;
        n_rd_last   = 1'b0;
        n_pc        = r_pc;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_fill_k    = r_fill_k;
        n_fill_pt   = r_fill_pt;
        n_last_pend = r_last_pend;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_le        = r_le;
        n_lt        = r_lt;
        n_row       = r_row;
        n_ranked    = r_ranked;
        n_front     = r_front;
        n_blocked   = r_blocked;
        n_fnum      = r_fnum;
        st_we       = 1'b0;
        st_waddr    = {r_pc[PT_W-1:0], r_pos};
        st_wdata    = i_objective_value;
        st_raddr    = {r_i, r_k};
        mx_we       = 1'b0;
        mx_waddr    = r_i;
        mx_wdata    = {RANK_W'(0), r_row};
        mx_raddr    = r_i;

        // Consume data returning from the previous cycle's read.
        case (r_rd_kind)
            RD_CMP: begin
                n_le = le_acc;
                n_lt = lt_acc;
                if (r_rd_last) begin
                    n_row[r_rd_j] = le_acc && lt_acc && (r_rd_j != r_i);
                end
            end
            RD_PEEL: begin
                // Write the front number back into the row of a front member.
                if (r_front[r_rd_j]) begin
                    mx_we    = 1'b1;
                    mx_waddr = r_rd_j;
                    mx_wdata = {r_fnum, mx_rdata[MAX_POINTS-1:0]};
                end
                if (!ranked_new[r_rd_j]) begin
                    n_blocked = r_blocked | mx_rdata[MAX_POINTS-1:0];
                end
            end
            default: ;
        endcase

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    st_we = stored;
                    if (!closes) begin
                        n_pos = r_pos + OBJ_W'(1);
                    end else begin
                        n_pos       = '0;
                        n_fill_k    = r_pos + OBJ_W'(1);
                        n_fill_pt   = r_pc[PT_W-1:0];
                        n_last_pend = i_last_of_set;
                        n_i         = '0;
                        n_k         = '0;
                        if (stored) begin
                            n_pc = r_pc + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
            S_FILL: begin
                st_we    = 1'b1;
                st_waddr = {r_fill_pt, r_fill_k};
                st_wdata = '0;
                n_fill_k = r_fill_k + OBJ_W'(1);
            end
            S_CACHE: begin
                n_rd_kind = RD_CACHE;
                n_rd_k    = r_k;
                n_k       = r_k + OBJ_W'(1);
                if (k_end) begin
                    n_k = '0;
                    n_j = '0;
                end
            end
            S_CMP: begin
                st_raddr  = {r_j, r_k};
                n_rd_kind = RD_CMP;
                n_rd_j    = r_j;
                n_rd_k    = r_k;
                n_rd_last = k_end;
                n_k       = r_k + OBJ_W'(1);
                if (k_end) begin
                    n_k = '0;
                    n_j = r_j + PT_W'(1);
                end
            end
            S_ROW_WR: begin
                mx_we = 1'b1;
                n_i   = r_i + PT_W'(1);
                if (i_end) begin
                    n_i       = '0;
                    n_ranked  = '0;
                    n_front   = '0;
                    n_blocked = '0;
                    n_fnum    = '0;
                end
            end
            S_PEEL: begin
                n_rd_kind = RD_PEEL;
                n_rd_j    = r_i;
                n_i       = r_i + PT_W'(1);
            end
            S_PEEL_END: begin
                // Close this sweep and form the next front.
                if (r_front != '0) begin
                    n_fnum = r_fnum + RANK_W'(1);
                end
                n_ranked  = ranked_new;
                n_front   = next_front;
                n_blocked = '0;
                n_i       = '0;
                n_j       = '0;
            end
            S_EMIT: begin
                mx_raddr  = r_j;
                n_rd_kind = RD_EMIT;
                n_rd_j    = r_j;
                n_j       = r_j + PT_W'(1);
            end
            S_EMIT_DRAIN: begin
                // Drop the set and return to loading.
                n_pc  = '0;
                n_pos = '0;
                n_ovf = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_strobe      = (r_rd_kind == RD_EMIT);
    assign o_point_index = r_rd_j;
    assign o_front_rank  = mx_rdata[MX_W-1:MAX_POINTS];
    assign o_last_result = (r_rd_j == nlast);
    assign o_truncated   = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_rd_kind   <= RD_NONE;
            r_nobj      <= NOBJ_RESET;
            r_pc        <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_fill_k    <= '0;
            r_last_pend <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_rd_last   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_kind   <= n_rd_kind;
            if (i_cfg_we) begin
                r_nobj <= i_cfg_wdata;
            end
            r_pc        <= n_pc;
            r_pos       <= n_pos;
            r_ovf       <= n_ovf;
            r_fill_k    <= n_fill_k;
            r_last_pend <= n_last_pend;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_rd_last   <= n_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_pt <= n_fill_pt;
        r_rd_j    <= n_rd_j;
        r_rd_k    <= n_rd_k;
        r_le      <= n_le;
        r_lt      <= n_lt;
        r_row     <= n_row;
        r_ranked  <= n_ranked;
        r_front   <= n_front;
        r_blocked <= n_blocked;
        r_fnum    <= n_fnum;
        if (r_rd_kind == RD_CACHE) begin
            r_cache[r_rd_k] <= $signed(st_rdata);
        end
    end

    // Objective store: one word per point and objective slot.
    nds_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ST_DEPTH)
    ) u_obj_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Dominance rows, each carrying its point's front number on top.
    nds_ram #(
        .WIDTH (MX_W),
        .DEPTH (MAX_POINTS)
    ) u_dom_matrix (
        .i_clk   (i_clk),
        .i_we    (mx_we),
        .i_waddr (mx_waddr),
        .i_wdata (mx_wdata),
        .i_raddr (mx_raddr),
        .o_rdata (mx_rdata)
    );
endmodule
`default_nettype wire
